/* design/rbtc_pkg.sv */
// ----------------------------------------------------------------------------
// rbtc_pkg
// Shared types, constants and pack/unpack helpers for the Bayer tone curve.
// ----------------------------------------------------------------------------
package rbtc_pkg;

  localparam int PIX_W         = 10;
  localparam int WORD_W        = 16;
  localparam int NUM_WORDS     = 5;
  localparam int STREAM_W      = WORD_W * NUM_WORDS;
  localparam int NUM_PIX       = 8;
  localparam int NUM_PAIRS     = NUM_PIX / 2;
  localparam int STEP_W        = $clog2(NUM_PAIRS);
  localparam int CURVE_ENTRIES = 1024;
  localparam int NUM_CURVES    = 4;
  localparam int CURVE_W       = $clog2(NUM_CURVES);
  localparam int TABLE_DEPTH   = NUM_CURVES * CURVE_ENTRIES;
  localparam int TABLE_AW      = $clog2(TABLE_DEPTH);
  localparam int GAIN_SHIFT    = 12;
  localparam int PROD_W        = PIX_W + WORD_W;
  localparam int SCALED_W      = PROD_W - GAIN_SHIFT;

  localparam logic [PIX_W-1:0] PIX_MAX     = 10'd1023;
  localparam logic [PIX_W-1:0] BLACK_RESET = 10'd32;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARED_INDEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL  = 2'd2;
  localparam int CFG_DATA_W = PIX_W;

  // curve modes
  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_CUSTOM = 2'd1;
  localparam logic [1:0] MODE_SHARED = 2'd2;

  // opcodes
  localparam logic OP_PROCESS  = 1'b0;
  localparam logic OP_TABLE_WR = 1'b1;

  typedef logic [NUM_PIX-1:0][PIX_W-1:0] pix8_t;

  typedef enum logic [1:0] {
    PK_BYPASS,
    PK_LOOKUP,
    PK_GAIN
  } px_kind_t;

  typedef struct packed {
    logic              opcode;
    logic              odd_row;
    logic [WORD_W-1:0] group_word0;
    logic [WORD_W-1:0] group_word1;
    logic [WORD_W-1:0] group_word2;
    logic [WORD_W-1:0] group_word3;
    logic [WORD_W-1:0] group_word4;
    logic [11:0]       table_address;
    logic [WORD_W-1:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word0;
    logic [WORD_W-1:0] out_word1;
    logic [WORD_W-1:0] out_word2;
    logic [WORD_W-1:0] out_word3;
    logic [WORD_W-1:0] out_word4;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       curve_mode;
    logic             shared_index;
    logic [PIX_W-1:0] black_level;
  } cfg_t;

  typedef struct packed {
    px_kind_t            kind;
    logic [PIX_W-1:0]    pix;
    logic [PIX_W-1:0]    res;
    logic [TABLE_AW-1:0] addr;
  } lane_cmd_t;

  typedef struct packed {
    logic                en;
    logic [TABLE_AW-1:0] addr;
    logic [WORD_W-1:0]   data;
  } tbl_wr_t;

  typedef struct packed {
    logic              valid;
    logic [STEP_W-1:0] step;
    logic              last;
  } iss_t;

  // pixel k sits at stream bits counted from the top, msb first
  function automatic pix8_t unpack_group(logic [STREAM_W-1:0] s);
    pix8_t p;
    for (int k = 0; k < NUM_PIX; k++) begin
      p[k] = s[STREAM_W-1-PIX_W*k -: PIX_W];
    end
    return p;
  endfunction

  function automatic logic [STREAM_W-1:0] pack_group(pix8_t p);
    logic [STREAM_W-1:0] s;
    for (int k = 0; k < NUM_PIX; k++) begin
      s[STREAM_W-1-PIX_W*k -: PIX_W] = p[k];
    end
    return s;
  endfunction

endpackage

/* design/rbtc_if.sv */
// ----------------------------------------------------------------------------
// rbtc_if
// Valid/ready channel interfaces for pixel-group input and result output.
// ----------------------------------------------------------------------------
interface rbtc_in_if;
  logic              valid;
  logic              ready;
  rbtc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rbtc_out_if;
  logic               valid;
  logic               ready;
  rbtc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/rbtc_seq.sv */
// ----------------------------------------------------------------------------
// rbtc_seq
// Input word register and pair sequencer: issues one pixel pair per cycle while the pipe advances.
// ----------------------------------------------------------------------------
module rbtc_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  rbtc_in_if.sink                 in_chan,
  input  rbtc_pkg::cfg_t          cfg,
  input  logic                    adv,
  output rbtc_pkg::lane_cmd_t     cmd_a,
  output rbtc_pkg::lane_cmd_t     cmd_b,
  output rbtc_pkg::tbl_wr_t       wr,
  output rbtc_pkg::iss_t          iss
);

  logic                                cur_valid_r;
  rbtc_pkg::in_item_t                  cur_r;
  logic [rbtc_pkg::STEP_W-1:0]         step_r;
  logic                                t0big_r;

  logic                                issue_last;
  logic                                in_accept;
  rbtc_pkg::pix8_t                     grp;
  logic [rbtc_pkg::PIX_W-1:0]          pe, po, re, ro, y;
  logic [rbtc_pkg::PIX_W:0]            ysum;
  rbtc_pkg::px_kind_t                  kind;
  logic [rbtc_pkg::CURVE_W-1:0]        curve_a, curve_b;
  logic [rbtc_pkg::PIX_W-1:0]          idx_a, idx_b;

  assign issue_last = (cur_r.opcode == rbtc_pkg::OP_TABLE_WR) ||
                      (step_r == rbtc_pkg::STEP_W'(rbtc_pkg::NUM_PAIRS - 1));
  assign in_chan.ready = !cur_valid_r || (adv && issue_last);
  assign in_accept = in_chan.valid && in_chan.ready;

  always_comb begin
    grp = rbtc_pkg::unpack_group({cur_r.group_word0, cur_r.group_word1, cur_r.group_word2,
                                  cur_r.group_word3, cur_r.group_word4});
    pe = grp[{step_r, 1'b0}];
    po = grp[{step_r, 1'b1}];
    re = (pe > cfg.black_level) ? pe - cfg.black_level : '0;
    ro = (po > cfg.black_level) ? po - cfg.black_level : '0;
    ysum = {1'b0, re} + {1'b0, ro};
    y = ysum[rbtc_pkg::PIX_W:1];

    unique case (cfg.curve_mode)
      rbtc_pkg::MODE_CUSTOM: kind = t0big_r ? rbtc_pkg::PK_GAIN : rbtc_pkg::PK_LOOKUP;
      rbtc_pkg::MODE_SHARED: kind = rbtc_pkg::PK_GAIN;
      default:               kind = rbtc_pkg::PK_BYPASS;
    endcase

    if (cfg.curve_mode == rbtc_pkg::MODE_SHARED) begin
      curve_a = {1'b0, cfg.shared_index};
      curve_b = {1'b0, cfg.shared_index};
    end else begin
      curve_a = {cur_r.odd_row, 1'b0};
      curve_b = {cur_r.odd_row, 1'b1};
    end

    idx_a = (kind == rbtc_pkg::PK_GAIN) ? y : pe;
    idx_b = (kind == rbtc_pkg::PK_GAIN) ? y : po;

    cmd_a.kind = kind;
    cmd_a.pix  = pe;
    cmd_a.res  = re;
    cmd_a.addr = {curve_a, idx_a};
    cmd_b.kind = kind;
    cmd_b.pix  = po;
    cmd_b.res  = ro;
    cmd_b.addr = {curve_b, idx_b};

    wr.en   = adv && cur_valid_r && (cur_r.opcode == rbtc_pkg::OP_TABLE_WR);
    wr.addr = cur_r.table_address[rbtc_pkg::TABLE_AW-1:0];
    wr.data = cur_r.table_value;

    iss.valid = cur_valid_r && (cur_r.opcode == rbtc_pkg::OP_PROCESS);
    iss.step  = step_r;
    iss.last  = issue_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      t0big_r     <= 1'b0;
    end else begin
      if (in_accept) begin
        cur_valid_r <= 1'b1;
        step_r      <= '0;
      end else if (adv && cur_valid_r) begin
        if (issue_last) begin
          cur_valid_r <= 1'b0;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
      // entry 0 above pixel range switches custom mode to gain
      if (wr.en && wr.addr == '0) begin
        t0big_r <= (wr.data > rbtc_pkg::WORD_W'(rbtc_pkg::PIX_MAX));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_r <= in_chan.data;
    end
  end

endmodule

/* design/rbtc_lane.sv */
// ----------------------------------------------------------------------------
// rbtc_lane
// One pixel lane: private curve table copy, lookup, gain multiply and clamp.
// ----------------------------------------------------------------------------
module rbtc_lane (
  input  logic                        clk,
  input  logic                        adv,
  input  rbtc_pkg::cfg_t              cfg,
  input  rbtc_pkg::lane_cmd_t         cmd,
  input  rbtc_pkg::tbl_wr_t           wr,
  output logic [rbtc_pkg::PIX_W-1:0]  px
);

  logic [rbtc_pkg::WORD_W-1:0]   mem [rbtc_pkg::TABLE_DEPTH];

  logic [rbtc_pkg::WORD_W-1:0]   rd_r;
  rbtc_pkg::px_kind_t            kind1_r, kind2_r;
  logic [rbtc_pkg::PIX_W-1:0]    pix1_r, res1_r, pix2_r, lut2_r, px_r;
  logic [rbtc_pkg::PROD_W-1:0]   prod_r;

  logic [rbtc_pkg::SCALED_W-1:0] scaled;
  logic [rbtc_pkg::SCALED_W:0]   gsum;
  logic [rbtc_pkg::PIX_W-1:0]    gained;
  logic [rbtc_pkg::PIX_W-1:0]    px_nxt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (adv) begin
      rd_r <= mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1_r <= cmd.kind;
      pix1_r  <= cmd.pix;
      res1_r  <= cmd.res;
      kind2_r <= kind1_r;
      pix2_r  <= pix1_r;
      lut2_r  <= rd_r[rbtc_pkg::PIX_W-1:0];
      prod_r  <= rbtc_pkg::PROD_W'(res1_r) * rbtc_pkg::PROD_W'(rd_r);
      px_r    <= px_nxt;
    end
  end

  always_comb begin
    scaled = prod_r[rbtc_pkg::PROD_W-1:rbtc_pkg::GAIN_SHIFT];
    gsum   = {1'b0, scaled} + (rbtc_pkg::SCALED_W + 1)'(cfg.black_level);
    gained = (gsum > (rbtc_pkg::SCALED_W + 1)'(rbtc_pkg::PIX_MAX)) ?
             rbtc_pkg::PIX_MAX : gsum[rbtc_pkg::PIX_W-1:0];
    case (kind2_r)
      rbtc_pkg::PK_LOOKUP: px_nxt = lut2_r;
      rbtc_pkg::PK_GAIN:   px_nxt = gained;
      default:             px_nxt = pix2_r;
    endcase
  end

  assign px = px_r;

endmodule

/* design/rbtc_merge.sv */
// ----------------------------------------------------------------------------
// rbtc_merge
// Collects the lane pairs of a group, repacks them and holds the result word.
// ----------------------------------------------------------------------------
module rbtc_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rbtc_pkg::iss_t              iss,
  input  logic [rbtc_pkg::PIX_W-1:0]  px_a,
  input  logic [rbtc_pkg::PIX_W-1:0]  px_b,
  output logic                        adv,
  rbtc_out_if.source                  out_chan
);

  localparam int HELD = rbtc_pkg::NUM_PAIRS - 1;

  rbtc_pkg::iss_t               s1_r, s2_r, s3_r;
  logic                         out_valid_r;
  rbtc_pkg::out_item_t          out_data_r;
  logic [rbtc_pkg::PIX_W-1:0]   pa_r [HELD];
  logic [rbtc_pkg::PIX_W-1:0]   pb_r [HELD];

  rbtc_pkg::pix8_t              grp;
  logic [rbtc_pkg::STREAM_W-1:0] stream;

  // whole pipe moves together; only a full, stalled output word holds it
  assign adv = !out_valid_r || out_chan.ready;

  always_comb begin
    for (int j = 0; j < HELD; j++) begin
      grp[2*j]   = pa_r[j];
      grp[2*j+1] = pb_r[j];
    end
    grp[2*HELD]   = px_a;
    grp[2*HELD+1] = px_b;
    stream = rbtc_pkg::pack_group(grp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      s3_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_r <= iss;
        s2_r <= s1_r;
        s3_r <= s2_r;
      end
      if (adv && s3_r.valid && s3_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_r.valid) begin
      if (!s3_r.last) begin
        pa_r[s3_r.step] <= px_a;
        pb_r[s3_r.step] <= px_b;
      end else begin
        out_data_r.out_word0 <= stream[5*rbtc_pkg::WORD_W-1 -: rbtc_pkg::WORD_W];
        out_data_r.out_word1 <= stream[4*rbtc_pkg::WORD_W-1 -: rbtc_pkg::WORD_W];
        out_data_r.out_word2 <= stream[3*rbtc_pkg::WORD_W-1 -: rbtc_pkg::WORD_W];
        out_data_r.out_word3 <= stream[2*rbtc_pkg::WORD_W-1 -: rbtc_pkg::WORD_W];
        out_data_r.out_word4 <= stream[rbtc_pkg::WORD_W-1 -: rbtc_pkg::WORD_W];
      end
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

/* design/raw_bayer_tone_curve.sv */
// ----------------------------------------------------------------------------
// raw_bayer_tone_curve
// Tone curve for packed 10-bit Bayer groups: bypass, curve lookup or gain.
// ----------------------------------------------------------------------------
// in_chan carries either a group of eight packed pixels (five 16-bit words)
// or a single curve table write; out_chan returns one result of five processed
// packed words per pixel group, in order. Table writes return nothing.
// A group is worked as four pixel pairs, one pair per cycle while the output
// is not stalled: the even pixel goes down lane A, the odd pixel down lane B,
// each lane owning a full copy of the 4096-entry curve table with one read
// port. That read port sets the rate; a new group or table write is taken as
// the last pair of a group issues. The result passes the lane read, product
// and pixel registers and the output word register. Writes land in program
// order, so a group always sees every table write accepted ahead of it.
// cfg_we/cfg_index/cfg_data write curve_mode, shared_index and black_level;
// change them only while the block is idle.
// Reset clears the sequencer and the output valid and restores the register
// defaults; the table holds no reset value and must be loaded before use.
// If the receiver stalls, the result word holds and the whole pipe freezes;
// one further item may still be taken into the input register meanwhile.
// ----------------------------------------------------------------------------
module raw_bayer_tone_curve (
  input  logic                               clk,
  input  logic                               rst_n,
  rbtc_in_if.sink                            in_chan,
  rbtc_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [rbtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbtc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rbtc_pkg::cfg_t          cfg_r;
  rbtc_pkg::lane_cmd_t     cmd_a, cmd_b;
  rbtc_pkg::tbl_wr_t       wr;
  rbtc_pkg::iss_t          iss;
  logic                    adv;
  logic [rbtc_pkg::PIX_W-1:0] px_a, px_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curve_mode   <= rbtc_pkg::MODE_BYPASS;
      cfg_r.shared_index <= 1'b0;
      cfg_r.black_level  <= rbtc_pkg::BLACK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbtc_pkg::CFG_CURVE_MODE:   cfg_r.curve_mode   <= cfg_data[1:0];
        rbtc_pkg::CFG_SHARED_INDEX: cfg_r.shared_index <= cfg_data[0];
        rbtc_pkg::CFG_BLACK_LEVEL:  cfg_r.black_level  <= cfg_data;
        default: ;
      endcase
    end
  end

  rbtc_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .adv     (adv),
    .cmd_a   (cmd_a),
    .cmd_b   (cmd_b),
    .wr      (wr),
    .iss     (iss)
  );

  rbtc_lane u_lane_a (
    .clk (clk),
    .adv (adv),
    .cfg (cfg_r),
    .cmd (cmd_a),
    .wr  (wr),
    .px  (px_a)
  );

  rbtc_lane u_lane_b (
    .clk (clk),
    .adv (adv),
    .cfg (cfg_r),
    .cmd (cmd_b),
    .wr  (wr),
    .px  (px_b)
  );

  rbtc_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .iss      (iss),
    .px_a     (px_a),
    .px_b     (px_b),
    .adv      (adv),
    .out_chan (out_chan)
  );

  // a table write never issues a pixel pair
  a_wr_no_pair: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !iss.valid)
    else $error("table write issued together with a pixel pair");

  // pairs of a group issue in consecutive order
  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    adv && iss.valid && !iss.last |=>
      iss.valid && iss.step == $past(iss.step) + 1'b1)
    else $error("pair sequence broken");

  // no new word is taken in the middle of a group
  a_no_take_mid: assert property (@(posedge clk) disable iff (!rst_n)
    iss.valid && !iss.last |-> !in_chan.ready)
    else $error("input ready in the middle of a group");

endmodule
